[sv/alr_pkg.sv]
`timescale 1ns / 1ps

package alr_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int FILL_W   = 8;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Width in which positions, counts and pointers are compared.
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_DN_RD,
    S_DN_WR,
    S_RD_REQ,
    S_RD_CAP,
    S_FINISH
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVAL,
    OP_UP_RD,
    OP_UP_WR,
    OP_INS_WR,
    OP_DN_RD,
    OP_DN_WR,
    OP_RD_REQ,
    OP_RD_CAP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] chk_status;
    logic       ins_shift;
    logic       del_shift;
    logic       up_last;
    logic       dn_last;
    logic       out_busy;
  } dp_status_t;

endpackage

[sv/alr_ram.sv]
`timescale 1ns / 1ps

module alr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/alr_ctrl.sv]
`timescale 1ns / 1ps

module alr_ctrl import alr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  ctrl_cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ctrl_cmd_o.op = OP_NONE;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_cmd_o.op = OP_LOAD;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl_cmd_o.op = OP_EVAL;
        if (dp_status_i.chk_status != ST_OK) begin
          state_d = S_FINISH;
        end else begin
          case (dp_status_i.cmd)
            CMD_INSERT: state_d = dp_status_i.ins_shift ? S_UP_RD : S_INS_WR;
            CMD_DELETE: state_d = dp_status_i.del_shift ? S_DN_RD : S_FINISH;
            CMD_READ:   state_d = S_RD_REQ;
            default:    state_d = S_FINISH;
          endcase
        end
      end
      S_UP_RD: begin
        ctrl_cmd_o.op = OP_UP_RD;
        state_d       = S_UP_WR;
      end
      S_UP_WR: begin
        ctrl_cmd_o.op = OP_UP_WR;
        state_d       = dp_status_i.up_last ? S_INS_WR : S_UP_RD;
      end
      S_INS_WR: begin
        ctrl_cmd_o.op = OP_INS_WR;
        state_d       = S_FINISH;
      end
      S_DN_RD: begin
        ctrl_cmd_o.op = OP_DN_RD;
        state_d       = S_DN_WR;
      end
      S_DN_WR: begin
        ctrl_cmd_o.op = OP_DN_WR;
        state_d       = dp_status_i.dn_last ? S_FINISH : S_DN_RD;
      end
      S_RD_REQ: begin
        ctrl_cmd_o.op = OP_RD_REQ;
        state_d       = S_RD_CAP;
      end
      S_RD_CAP: begin
        ctrl_cmd_o.op = OP_RD_CAP;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (!dp_status_i.out_busy) begin
          ctrl_cmd_o.op = OP_FINISH;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[sv/alr_dp.sv]
`timescale 1ns / 1ps

module alr_dp import alr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                ctrl_cmd_i,
  output dp_status_t               dp_status_o,
  input  logic [1:0]               cmd_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [FILL_W-1:0]        fill_after_o,
  output logic signed [DATA_W-1:0] read_value_o
);

  logic [1:0]               cmd_q;
  logic [CMP_W-1:0]         pos_q;
  logic [DATA_W-1:0]        val_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CMP_W-1:0]         ptr_q;
  logic [1:0]               res_q;
  logic [DATA_W-1:0]        rd_q;
  logic                     out_valid_q;
  logic [1:0]               status_q;
  logic [FILL_W-1:0]        fill_q;
  logic [DATA_W-1:0]        read_value_q;

  logic [CMP_W-1:0]         count_x;
  logic [CMP_W-1:0]         ptr_m1;
  logic [CMP_W-1:0]         ptr_p1;
  logic [CMP_W-1:0]         pos_p1;
  logic [CMP_W-1:0]         count_dx;
  logic [1:0]               chk_status;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  assign count_x = CMP_W'(count_q);
  assign ptr_m1  = ptr_q - CMP_W'(1);
  assign ptr_p1  = ptr_q + CMP_W'(1);
  assign pos_p1  = pos_q + CMP_W'(1);

  always_comb begin
    chk_status = ST_BAD_POS;
    case (cmd_q)
      CMD_INSERT: begin
        if (pos_q > count_x) begin
          chk_status = ST_BAD_POS;
        end else if (count_x >= CMP_W'(CAPACITY)) begin
          chk_status = ST_FULL;
        end else begin
          chk_status = ST_OK;
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (pos_q < count_x) begin
          chk_status = ST_OK;
        end
      end
      default: chk_status = ST_BAD_POS;
    endcase
  end

  assign dp_status_o.cmd        = cmd_q;
  assign dp_status_o.chk_status = chk_status;
  assign dp_status_o.ins_shift  = count_x > pos_q;
  assign dp_status_o.del_shift  = pos_p1 < count_x;
  assign dp_status_o.up_last    = ptr_m1 == pos_q;
  assign dp_status_o.dn_last    = ptr_p1 == count_x;
  assign dp_status_o.out_busy   = out_valid_q && out_stall_i;

  // Memory port steering for each step of the shift and read sequences.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[AW-1:0];
    case (ctrl_cmd_i.op)
      OP_UP_RD: ram_raddr = ptr_m1[AW-1:0];
      OP_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[AW-1:0];
      end
      OP_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = val_q;
      end
      OP_DN_RD: ram_raddr = ptr_q[AW-1:0];
      OP_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_m1[AW-1:0];
      end
      OP_RD_REQ: ram_raddr = pos_q[AW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (res_q == ST_OK) begin
      if (cmd_q == CMD_INSERT) begin
        count_d = count_q + CNT_W'(1);
      end else if (cmd_q == CMD_DELETE) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  assign count_dx = CMP_W'(count_d);

  always_ff @(posedge clk_i) begin
    case (ctrl_cmd_i.op)
      OP_LOAD: begin
        cmd_q <= cmd_i;
        pos_q <= CMP_W'(position_i);
        val_q <= value_i;
      end
      OP_EVAL: begin
        res_q <= chk_status;
        rd_q  <= '0;
        ptr_q <= (cmd_q == CMD_INSERT) ? count_x : pos_p1;
      end
      OP_UP_WR:  ptr_q <= ptr_m1;
      OP_DN_WR:  ptr_q <= ptr_p1;
      OP_RD_CAP: rd_q  <= ram_rdata;
      OP_FINISH: begin
        status_q     <= res_q;
        fill_q       <= count_dx[FILL_W-1:0];
        read_value_q <= rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_cmd_i.op == OP_FINISH) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  alr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign fill_after_o = fill_q;
  assign read_value_o = read_value_q;

endmodule

[sv/array_list_insert_delete_core.sv]
// Requests are taken one at a time; the next is accepted only after the result of
// the last one has been loaded into the result register and the controller is idle.
// Each moved entry is a registered RAM read, then the write one slot over.
// Reset (rst_ni, asynchronous, active low) empties the list; the RAM itself is not cleared.
`timescale 1ns / 1ps

module array_list_insert_delete_core import alr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [FILL_W-1:0]        fill_after_o,
  output logic signed [DATA_W-1:0] read_value_o
);

  // The controller sequences each request: it checks the position against the fill
  // count, then walks the shift pointer one entry at a time through the RAM. The
  // datapath holds the request, the fill count, the pointer and the result register.
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  alr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dp_status_i (dp_status),
    .ctrl_cmd_o  (ctrl_cmd)
  );

  // The result register lets a finished result wait for the consumer while the
  // controller returns to idle and takes the next request.
  alr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_cmd_i   (ctrl_cmd),
    .dp_status_o  (dp_status),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .fill_after_o (fill_after_o),
    .read_value_o (read_value_o)
  );

endmodule

[sv/alr_checker.sv]
`timescale 1ns / 1ps

module alr_checker import alr_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [1:0]               status_o,
  input logic [FILL_W-1:0]        fill_after_o,
  input logic signed [DATA_W-1:0] read_value_o
);

  localparam logic [FILL_W-1:0] CAP_LOW = FILL_W'(CAPACITY);

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every request passes through the check state, so no two are taken back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted on consecutive cycles");

  // A failed request never carries read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> read_value_o == '0)
    else $error("read data on a failed request");

  // A full rejection reports a full list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> fill_after_o == CAP_LOW)
    else $error("full status with list not full");

  // The fill count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (CAPACITY < 256) |-> fill_after_o <= CAP_LOW)
    else $error("fill count above capacity");

endmodule

bind array_list_insert_delete_core alr_checker u_alr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .fill_after_o (fill_after_o),
  .read_value_o (read_value_o)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import alr_pkg::*;

  // Command code 3 has no meaning in the block; it must be rejected as a bad position.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 1500;
  localparam int QUIET_FIRST     = 500;
  localparam int QUIET_LAST      = 800;
  localparam int IDLE_PERCENT    = 37;
  localparam int PRESSURE_AFTER  = 100;
  localparam int PRESSURE_CYCLES = 400;
  // The slowest request is an insert at the head of a nearly full list.
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 40;
  localparam int TIMEOUT_NS      = 10_000_000;

  typedef struct packed {
    logic [1:0]        status;
    logic [FILL_W-1:0] fill;
    logic [DATA_W-1:0] word;
  } list_result_t;

  // Tracks the list contents as requests are accepted and holds the results they
  // should produce, oldest first.
  class list_scoreboard;
    logic [DATA_W-1:0] words [CAPACITY];
    int                held;
    int                errors;
    int                results_seen;
    list_result_t      awaited [$];

    function new();
      held         = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void note_request(logic [1:0] cmd, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] value);
      list_result_t r;
      int           p;
      int           j;
      p        = pos;
      r.status = ST_BAD_POS;
      r.word   = '0;
      case (cmd)
        CMD_INSERT: begin
          // The position check wins over the full check.
          if (p > held) begin
            r.status = ST_BAD_POS;
          end else if (held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (j = held; j > p; j--) words[j] = words[j-1];
            words[p] = value;
            held++;
            r.status = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (p < held) begin
            for (j = p + 1; j < held; j++) words[j-1] = words[j];
            held--;
            r.status = ST_OK;
          end
        end
        CMD_READ: begin
          if (p < held) begin
            r.word   = words[p];
            r.status = ST_OK;
          end
        end
        default: r.status = ST_BAD_POS;
      endcase
      r.fill = FILL_W'(held);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [FILL_W-1:0] fill,
                               logic [DATA_W-1:0] word);
      list_result_t e;
      results_seen++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d fill %0d value %0d",
                 $time, status, fill, $signed(word));
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      end
      if (fill !== e.fill) begin
        errors++;
        $display("%0t: fill_after expected %0d actual %0d", $time, e.fill, fill);
      end
      if (word !== e.word) begin
        errors++;
        $display("%0t: read_value expected %0d actual %0d", $time,
                 $signed(e.word), $signed(word));
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [1:0]               cmd        = CMD_INSERT;
  logic [POS_W-1:0]         position   = '0;
  logic signed [DATA_W-1:0] value      = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [1:0]               status;
  logic [FILL_W-1:0]        fill_after;
  logic signed [DATA_W-1:0] read_value;

  // While set, neither side inserts idle cycles.
  bit                       no_idle    = 1'b0;

  list_scoreboard           sb = new();

  array_list_insert_delete_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .position_i   (position),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .fill_after_o (fill_after),
    .read_value_o (read_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one request, with random idle cycles ahead of it, and returns once the block
  // has taken it. The payload is held steady while the block stalls.
  task automatic issue(input logic [1:0] c, input logic [POS_W-1:0] p,
                       input logic [DATA_W-1:0] v);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c, p, v);
  endtask

  // A position from 0 to hi, leaning toward the two ends of the range.
  function automatic logic [POS_W-1:0] pick_position(int hi);
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return '0;
    if (roll < 40) return POS_W'(hi);
    return POS_W'($urandom_range(hi));
  endfunction

  // Stimulus: a short directed pass over the corner cases, then random fill-and-drain
  // waves so that the list repeatedly climbs to full and falls back to empty.
  initial begin
    int  n;
    int  i;
    int  roll;
    int  top;
    bit  growing;
    logic [DATA_W-1:0] v;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: every read, delete and insert past the end is refused.
    issue(CMD_READ,   8'd0,   $urandom());
    issue(CMD_DELETE, 8'd0,   $urandom());
    issue(CMD_INSERT, 8'd1,   $urandom());
    issue(CMD_INSERT, 8'hFF,  32'hFFFF_FFFF);
    // Build a short list through head, tail and middle inserts of extreme words.
    issue(CMD_INSERT, 8'd0,   32'h7FFF_FFFF);
    issue(CMD_INSERT, 8'd0,   32'h8000_0000);
    issue(CMD_INSERT, 8'd2,   32'hFFFF_FFFF);
    issue(CMD_INSERT, 8'd1,   32'h0000_0000);
    issue(CMD_INSERT, 8'd2,   32'hAAAA_AAAA);
    issue(CMD_INSERT, 8'd4,   32'h5555_5555);
    issue(CMD_INSERT, 8'd7,   $urandom());
    for (i = 0; i < 6; i++) issue(CMD_READ, POS_W'(i), $urandom());
    issue(CMD_READ,   8'd6,   $urandom());
    issue(CMD_UNUSED, 8'd0,   $urandom());
    issue(CMD_DELETE, 8'd6,   $urandom());
    // Remove the head, the tail and then a middle entry.
    issue(CMD_DELETE, 8'd0,   $urandom());
    issue(CMD_DELETE, 8'd4,   $urandom());
    issue(CMD_DELETE, 8'd1,   $urandom());
    issue(CMD_READ,   8'hFF,  $urandom());
    issue(CMD_DELETE, 8'hFF,  $urandom());

    growing = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= QUIET_FIRST && n < QUIET_LAST);
      v       = $urandom();
      roll    = $urandom_range(99);
      top     = (sb.held == 0) ? 0 : sb.held - 1;
      if (sb.held == 0) growing = 1'b1;
      if (sb.held == CAPACITY) begin
        // Full list: a legal position reports full, a position past the end still reports a
        // bad position. Then the list is drained.
        issue(CMD_INSERT, pick_position(CAPACITY), v);
        issue(CMD_INSERT, POS_W'($urandom_range(255, CAPACITY + 1)), $urandom());
        growing = 1'b0;
      end else if (roll < 5) begin
        issue(2'($urandom_range(3)), POS_W'($urandom_range(255)), v);
      end else if (growing) begin
        if (roll < 70)      issue(CMD_INSERT, pick_position(sb.held), v);
        else if (roll < 85) issue(CMD_READ,   pick_position(top), v);
        else                issue(CMD_DELETE, pick_position(top), v);
      end else begin
        if (roll < 65)      issue(CMD_DELETE, pick_position(top), v);
        else if (roll < 80) issue(CMD_READ,   pick_position(top), v);
        else                issue(CMD_INSERT, pick_position(sb.held), v);
      end
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Any stray result after the last expected one still gets caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side stall. Once, early on, the stall is held for a long stretch so that the
  // block sits on a finished result and has to refuse new requests.
  initial begin
    int hold_left;
    bit pressed;
    hold_left = 0;
    pressed   = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && sb.results_seen >= PRESSURE_AFTER) begin
        pressed   = 1'b1;
        hold_left = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(status, fill_after, read_value);
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
